// ===== design/ssrg_pkg.sv =====
package ssrg_pkg;

   localparam int unsigned MASTER_CLOCK_HZ = 144000;
   localparam int unsigned TICK_RATE_HZ    = 14400;
   localparam int unsigned MOTOR_COUNT     = 2;

   localparam int unsigned MOTOR_W    = $clog2(MOTOR_COUNT);
   localparam int unsigned RATE_W     = 16;
   localparam int unsigned PERIOD_W   = $clog2(MASTER_CLOCK_HZ + 1);
   localparam int unsigned CD_W       = PERIOD_W + 1;
   localparam int unsigned DIV_CNT_W  = $clog2(PERIOD_W);
   localparam int unsigned STEP_W     = 32;
   localparam int unsigned COIL_W     = 4;
   localparam int unsigned PHASE_W    = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned TICK_DEC       = MASTER_CLOCK_HZ / TICK_RATE_HZ;
   localparam int unsigned STOP_RATE      = 1000;
   localparam int unsigned RATE_MAX_RESET = 1000;
   localparam int unsigned RATE_MIN_RESET = 1;

   // Lowest value a countdown can take after a tick.
   localparam logic [CD_W-1:0] CD_FLOOR = CD_W'(0) - CD_W'(TICK_DEC - 1);

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_SPEED = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED  = 2'd0,
      CSR_RATE_MAX = 2'd1,
      CSR_RATE_MIN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   typedef struct packed {
      logic start_tick;
      logic start_speed;
      logic div_step;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   function automatic logic [COIL_W-1:0] coil_of(input logic [MOTOR_W-1:0] motor,
                                                 input logic [PHASE_W-1:0] ph);
      logic [PHASE_W-1:0] idx;
      logic [COIL_W-1:0]  c;
      idx = motor[0] ? ~ph : ph;
      case (idx)
         2'd0: begin
            c = 4'h9;
         end
         2'd1: begin
            c = 4'h5;
         end
         2'd2: begin
            c = 4'h6;
         end
         2'd3: begin
            c = 4'hA;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== design/ssrg_ctrl.sv =====
module ssrg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ssrg_pkg::cmd_type  cmd,
   input  ssrg_pkg::stat_type stat
);

   ssrg_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssrg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ssrg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ssrg_pkg::ACT_SPEED) begin
                  cmd.start_speed = 1'b1;
                  state_in        = ssrg_pkg::ST_DIV;
               end else begin
                  cmd.start_tick = 1'b1;
                  state_in       = ssrg_pkg::ST_EMIT;
               end
            end
         end
         ssrg_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.commit = 1'b1;
               state_in   = ssrg_pkg::ST_EMIT;
            end
         end
         ssrg_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ssrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssrg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_tick_to_emit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ssrg_pkg::ACT_TICK)
      |=> state_ff == ssrg_pkg::ST_EMIT)
      else $error("tick word did not go straight to the result stage");

   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssrg_pkg::ST_DIV && stat.div_last) |=> state_ff == ssrg_pkg::ST_EMIT)
      else $error("division end did not lead to the result stage");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ssrg_pkg::ST_EMIT))
      else $error("result word raised outside the result stage");
`endif

endmodule

// ===== design/ssrg_dp.sv =====
module ssrg_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssrg_pkg::cmd_type                      cmd,
   output ssrg_pkg::stat_type                     stat,
   input  logic                                   csr_we,
   input  logic [ssrg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ssrg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [ssrg_pkg::MOTOR_W-1:0]           req_motor,
   input  logic signed [ssrg_pkg::RATE_W-1:0]     req_speed,
   output logic [ssrg_pkg::COIL_W-1:0]            rsp_left_coils,
   output logic [ssrg_pkg::COIL_W-1:0]            rsp_right_coils,
   output logic signed [ssrg_pkg::STEP_W-1:0]     rsp_left_steps,
   output logic signed [ssrg_pkg::STEP_W-1:0]     rsp_right_steps
);

   logic                          enabled_ff;
   logic [ssrg_pkg::RATE_W-1:0]   rate_max_ff;
   logic [ssrg_pkg::RATE_W-1:0]   rate_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         rate_max_ff <= ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MAX_RESET);
         rate_min_ff <= ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MIN_RESET);
      end else if (csr_we) begin
         if (csr_index == ssrg_pkg::CSR_ENABLED) begin
            enabled_ff <= csr_wdata[0];
         end
         if (csr_index == ssrg_pkg::CSR_RATE_MAX) begin
            rate_max_ff <= csr_wdata;
         end
         if (csr_index == ssrg_pkg::CSR_RATE_MIN) begin
            rate_min_ff <= csr_wdata;
         end
      end
   end

   logic coils_off;
   assign coils_off = csr_we && csr_index == ssrg_pkg::CSR_ENABLED && !csr_wdata[0];

   // Speed clamping, evaluated as the word is taken.
   logic signed [ssrg_pkg::RATE_W+1:0] spd_x, max_x, min_x, neg_x;
   logic [ssrg_pkg::RATE_W-1:0]        rate_sel;
   ssrg_pkg::dir_type                  dir_sel;

   always_comb begin
      spd_x = {{2{req_speed[ssrg_pkg::RATE_W-1]}}, req_speed};
      max_x = {2'b00, rate_max_ff};
      min_x = {2'b00, rate_min_ff};
      neg_x = -spd_x;
      if (spd_x > max_x) begin
         rate_sel = rate_max_ff;
         dir_sel  = ssrg_pkg::DIR_FWD;
      end else if (spd_x < -max_x) begin
         rate_sel = rate_max_ff;
         dir_sel  = ssrg_pkg::DIR_REV;
      end else if (spd_x >= min_x) begin
         rate_sel = spd_x[ssrg_pkg::RATE_W-1:0];
         dir_sel  = ssrg_pkg::DIR_FWD;
      end else if (spd_x <= -min_x) begin
         rate_sel = neg_x[ssrg_pkg::RATE_W-1:0];
         dir_sel  = ssrg_pkg::DIR_REV;
      end else begin
         rate_sel = ssrg_pkg::RATE_W'(ssrg_pkg::STOP_RATE);
         dir_sel  = ssrg_pkg::DIR_STOP;
      end
      if (rate_sel == '0) begin
         rate_sel = ssrg_pkg::RATE_W'(1);
      end
   end

   // Restoring divider: one quotient bit per cycle.
   logic [ssrg_pkg::MOTOR_W-1:0]   motor_ff;
   ssrg_pkg::dir_type              dir_pend_ff;
   logic [ssrg_pkg::RATE_W-1:0]    rate_ff;
   logic [ssrg_pkg::PERIOD_W-1:0]  acc_ff, acc_in;
   logic [ssrg_pkg::RATE_W-1:0]    rem_ff, rem_in;
   logic [ssrg_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [ssrg_pkg::RATE_W:0]      rem_shift, rem_diff;
   logic                           fits;

   always_comb begin
      rem_shift = {rem_ff, acc_ff[ssrg_pkg::PERIOD_W-1]};
      rem_diff  = rem_shift - {1'b0, rate_ff};
      fits      = rem_shift >= {1'b0, rate_ff};
      rem_in    = fits ? rem_diff[ssrg_pkg::RATE_W-1:0] : rem_shift[ssrg_pkg::RATE_W-1:0];
      acc_in    = {acc_ff[ssrg_pkg::PERIOD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (cmd.start_speed) begin
         motor_ff    <= req_motor;
         dir_pend_ff <= dir_sel;
         rate_ff     <= rate_sel;
         acc_ff      <= ssrg_pkg::PERIOD_W'(ssrg_pkg::MASTER_CLOCK_HZ);
         rem_ff      <= '0;
         cnt_ff      <= '0;
      end else if (cmd.div_step) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + ssrg_pkg::DIV_CNT_W'(1);
      end
   end

   assign stat.div_last = cnt_ff == ssrg_pkg::DIV_CNT_W'(ssrg_pkg::PERIOD_W - 1);

   // Per-motor state.
   ssrg_pkg::dir_type              dir_ff    [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::PHASE_W-1:0]   phase_ff  [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::PERIOD_W-1:0]  period_ff [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::CD_W-1:0]      cd_ff     [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::STEP_W-1:0]    steps_ff  [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::COIL_W-1:0]    coil_ff   [ssrg_pkg::MOTOR_COUNT];

   for (genvar m = 0; m < ssrg_pkg::MOTOR_COUNT; m++) begin : g_motor
      logic [ssrg_pkg::CD_W-1:0]    cd_sub, cd_next;
      logic                         wrap;
      logic [ssrg_pkg::PHASE_W-1:0] ph_up, ph_dn;

      always_comb begin
         if (!cd_ff[m][ssrg_pkg::CD_W-1] && cd_ff[m] != '0) begin
            cd_sub = cd_ff[m] - ssrg_pkg::CD_W'(ssrg_pkg::TICK_DEC);
         end else begin
            cd_sub = cd_ff[m];
         end
         wrap    = cd_sub[ssrg_pkg::CD_W-1] || cd_sub == '0;
         cd_next = wrap ? cd_sub + {1'b0, period_ff[m]} : cd_sub;
         ph_up   = phase_ff[m] + ssrg_pkg::PHASE_W'(1);
         ph_dn   = phase_ff[m] - ssrg_pkg::PHASE_W'(1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dir_ff[m]    <= ssrg_pkg::DIR_STOP;
            phase_ff[m]  <= '0;
            period_ff[m] <= ssrg_pkg::PERIOD_W'(1);
            cd_ff[m]     <= '0;
            steps_ff[m]  <= '0;
            coil_ff[m]   <= '0;
         end else begin
            if (cmd.commit && motor_ff == ssrg_pkg::MOTOR_W'(m)) begin
               dir_ff[m]    <= dir_pend_ff;
               period_ff[m] <= acc_in;
               cd_ff[m]     <= {1'b0, acc_in};
            end else if (cmd.start_tick && enabled_ff) begin
               cd_ff[m] <= cd_next;
               if (wrap) begin
                  case (dir_ff[m])
                     ssrg_pkg::DIR_FWD: begin
                        steps_ff[m] <= steps_ff[m] + ssrg_pkg::STEP_W'(1);
                        phase_ff[m] <= ph_up;
                        coil_ff[m]  <= ssrg_pkg::coil_of(ssrg_pkg::MOTOR_W'(m), ph_up);
                     end
                     ssrg_pkg::DIR_REV: begin
                        steps_ff[m] <= steps_ff[m] - ssrg_pkg::STEP_W'(1);
                        phase_ff[m] <= ph_dn;
                        coil_ff[m]  <= ssrg_pkg::coil_of(ssrg_pkg::MOTOR_W'(m), ph_dn);
                     end
                     default: begin
                        coil_ff[m] <= '0;
                     end
                  endcase
               end
            end
            if (coils_off) begin
               coil_ff[m] <= '0;
            end
         end
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_left_coils  <= coil_ff[0];
         rsp_right_coils <= coil_ff[1];
         rsp_left_steps  <= steps_ff[0];
         rsp_right_steps <= steps_ff[1];
      end
   end

`ifndef SYNTHESIS
   a_commit_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.div_last)
      else $error("period committed before the division finished");

   a_cd_floor_left: assert property (@(posedge clock) disable iff (reset)
      cd_ff[0][ssrg_pkg::CD_W-1] |-> cd_ff[0] >= ssrg_pkg::CD_FLOOR)
      else $error("left countdown fell below one tick");

   a_cd_floor_right: assert property (@(posedge clock) disable iff (reset)
      cd_ff[1][ssrg_pkg::CD_W-1] |-> cd_ff[1] >= ssrg_pkg::CD_FLOOR)
      else $error("right countdown fell below one tick");
`endif

endmodule

// ===== design/stepper_step_rate_generator.sv =====
// Two-motor full-step stepper rate generator. A tick word goes from idle straight
// to the result stage; a set-speed word first passes through the restoring
// divider, which forms the step period one quotient bit per cycle, before it
// reaches the result stage. One word is worked on at a time, and the next word is taken
// as soon as the result is in the output register, even while it waits there.
// Configuration writes through the csr port take effect at once and should be
// made only while no word is in flight.
module stepper_step_rate_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_action,
   input  logic [ssrg_pkg::MOTOR_W-1:0]           req_motor,
   input  logic signed [ssrg_pkg::RATE_W-1:0]     req_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ssrg_pkg::COIL_W-1:0]            rsp_left_coils,
   output logic [ssrg_pkg::COIL_W-1:0]            rsp_right_coils,
   output logic signed [ssrg_pkg::STEP_W-1:0]     rsp_left_steps,
   output logic signed [ssrg_pkg::STEP_W-1:0]     rsp_right_steps,
   input  logic                                   csr_we,
   input  logic [ssrg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ssrg_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   ssrg_pkg::cmd_type  cmd;
   ssrg_pkg::stat_type stat;

   ssrg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   ssrg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_motor       (req_motor),
      .req_speed       (req_speed),
      .rsp_left_coils  (rsp_left_coils),
      .rsp_right_coils (rsp_right_coils),
      .rsp_left_steps  (rsp_left_steps),
      .rsp_right_steps (rsp_right_steps)
   );

endmodule

// ===== dv/ssrg_checker.sv =====
module ssrg_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_action,
   input  logic [ssrg_pkg::MOTOR_W-1:0]        req_motor,
   input  logic signed [ssrg_pkg::RATE_W-1:0]  req_speed,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ssrg_pkg::COIL_W-1:0]         rsp_left_coils,
   input  logic [ssrg_pkg::COIL_W-1:0]         rsp_right_coils,
   input  logic signed [ssrg_pkg::STEP_W-1:0]  rsp_left_steps,
   input  logic signed [ssrg_pkg::STEP_W-1:0]  rsp_right_steps,
   input  logic                                csr_we,
   input  logic [ssrg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssrg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding
);

   // Coil sequences packed one nibble per phase, phase 0 in the lowest nibble.
   localparam logic [15:0] LEFT_SEQUENCE  = 16'hA659;
   localparam logic [15:0] RIGHT_SEQUENCE = 16'h956A;

   typedef struct packed {
      logic [ssrg_pkg::COIL_W-1:0] left_coils;
      logic [ssrg_pkg::COIL_W-1:0] right_coils;
      logic [ssrg_pkg::STEP_W-1:0] left_steps;
      logic [ssrg_pkg::STEP_W-1:0] right_steps;
   } motor_report_type;

   motor_report_type    expected_reports [$];
   motor_report_type    want;
   int                  results_seen;

   logic                          drive_enabled;
   logic [ssrg_pkg::RATE_W-1:0]   max_rate;
   logic [ssrg_pkg::RATE_W-1:0]   min_rate;
   ssrg_pkg::dir_type             heading     [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::PHASE_W-1:0]  rotor_phase [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::PERIOD_W-1:0] step_period [ssrg_pkg::MOTOR_COUNT];
   int                            step_timer  [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::STEP_W-1:0]   step_total  [ssrg_pkg::MOTOR_COUNT];
   logic [ssrg_pkg::COIL_W-1:0]   coil_drive  [ssrg_pkg::MOTOR_COUNT];

   initial begin
      mismatches = 0;
      outstanding = 0;
      results_seen = 0;
   end

   function automatic logic [ssrg_pkg::COIL_W-1:0] coil_pattern_for(input int m,
                                                                    input logic [1:0] ph);
      logic [15:0] sequence_bits;
      sequence_bits = (m == 0) ? LEFT_SEQUENCE : RIGHT_SEQUENCE;
      return sequence_bits[ph*4 +: 4];
   endfunction

   function automatic void load_speed(input int m, input int spd);
      int                mx;
      int                mn;
      int                rate;
      ssrg_pkg::dir_type d;
      mx = int'(max_rate);
      mn = int'(min_rate);
      if (spd > mx) begin
         rate = mx;
         d = ssrg_pkg::DIR_FWD;
      end else if (spd < -mx) begin
         rate = mx;
         d = ssrg_pkg::DIR_REV;
      end else if (spd >= mn) begin
         rate = spd;
         d = ssrg_pkg::DIR_FWD;
      end else if (spd <= -mn) begin
         rate = -spd;
         d = ssrg_pkg::DIR_REV;
      end else begin
         rate = int'(ssrg_pkg::STOP_RATE);
         d = ssrg_pkg::DIR_STOP;
      end
      if (rate == 0) begin
         rate = 1;
      end
      heading[m] = d;
      step_period[m] = ssrg_pkg::PERIOD_W'(int'(ssrg_pkg::MASTER_CLOCK_HZ) / rate);
      step_timer[m] = int'(step_period[m]);
   endfunction

   function automatic void advance_tick();
      int decrement;
      decrement = int'(ssrg_pkg::TICK_DEC);
      for (int m = 0; m < ssrg_pkg::MOTOR_COUNT; m++) begin
         if (step_timer[m] > 0) begin
            step_timer[m] = step_timer[m] - decrement;
         end
         if (step_timer[m] <= 0) begin
            step_timer[m] = step_timer[m] + int'(step_period[m]);
            case (heading[m])
               ssrg_pkg::DIR_FWD: begin
                  step_total[m] = step_total[m] + ssrg_pkg::STEP_W'(1);
                  rotor_phase[m] = rotor_phase[m] + 2'd1;
                  coil_drive[m] = coil_pattern_for(m, rotor_phase[m]);
               end
               ssrg_pkg::DIR_REV: begin
                  step_total[m] = step_total[m] - ssrg_pkg::STEP_W'(1);
                  rotor_phase[m] = rotor_phase[m] + 2'd3;
                  coil_drive[m] = coil_pattern_for(m, rotor_phase[m]);
               end
               default: begin
                  coil_drive[m] = '0;
               end
            endcase
         end
      end
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] wanted);
      $display("mismatch in %s of result %0d: got %h, expected %h",
               field, results_seen, got, wanted);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_reports.delete();
         drive_enabled = 1'b0;
         max_rate = ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MAX_RESET);
         min_rate = ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MIN_RESET);
         for (int m = 0; m < ssrg_pkg::MOTOR_COUNT; m++) begin
            heading[m] = ssrg_pkg::DIR_STOP;
            rotor_phase[m] = '0;
            step_period[m] = ssrg_pkg::PERIOD_W'(1);
            step_timer[m] = 0;
            step_total[m] = '0;
            coil_drive[m] = '0;
         end
      end else begin
         if (csr_we) begin
            case (ssrg_pkg::csr_index_type'(csr_index))
               ssrg_pkg::CSR_ENABLED: begin
                  drive_enabled = csr_wdata[0];
                  if (!csr_wdata[0]) begin
                     for (int m = 0; m < ssrg_pkg::MOTOR_COUNT; m++) begin
                        coil_drive[m] = '0;
                     end
                  end
               end
               ssrg_pkg::CSR_RATE_MAX: begin
                  max_rate = csr_wdata[ssrg_pkg::RATE_W-1:0];
               end
               ssrg_pkg::CSR_RATE_MIN: begin
                  min_rate = csr_wdata[ssrg_pkg::RATE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_action == ssrg_pkg::ACT_SPEED) begin
               load_speed(int'(req_motor), int'(req_speed));
            end else if (drive_enabled) begin
               advance_tick();
            end
            want.left_coils = coil_drive[0];
            want.right_coils = coil_drive[1];
            want.left_steps = step_total[0];
            want.right_steps = step_total[1];
            expected_reports.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               flag_mismatch("word with nothing expected", '0, '0);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_left_coils !== want.left_coils) begin
                  flag_mismatch("left_coils", 32'(rsp_left_coils), 32'(want.left_coils));
               end
               if (rsp_right_coils !== want.right_coils) begin
                  flag_mismatch("right_coils", 32'(rsp_right_coils), 32'(want.right_coils));
               end
               if (rsp_left_steps !== want.left_steps) begin
                  flag_mismatch("left_steps", rsp_left_steps, want.left_steps);
               end
               if (rsp_right_steps !== want.right_steps) begin
                  flag_mismatch("right_steps", rsp_right_steps, want.right_steps);
               end
            end
            results_seen++;
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

// ===== dv/tb.sv =====
module tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int BATCHES       = 8;
   localparam int BATCH_WORDS   = 67;
   localparam logic [ssrg_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_action;
   logic [ssrg_pkg::MOTOR_W-1:0]        req_motor;
   logic signed [ssrg_pkg::RATE_W-1:0]  req_speed;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [ssrg_pkg::COIL_W-1:0]         rsp_left_coils;
   logic [ssrg_pkg::COIL_W-1:0]         rsp_right_coils;
   logic signed [ssrg_pkg::STEP_W-1:0]  rsp_left_steps;
   logic signed [ssrg_pkg::STEP_W-1:0]  rsp_right_steps;
   logic                                csr_we;
   logic [ssrg_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [ssrg_pkg::CSR_DATA_W-1:0]     csr_wdata;

   int                            mismatches;
   int                            outstanding;
   int                            sender_idle_pct;
   int                            receiver_idle_pct;
   int                            cycles = 0;
   int                            tick_words = 0;
   int                            speed_words = 0;
   int                            csr_writes = 0;
   logic [ssrg_pkg::RATE_W-1:0]   cur_rate_max;
   logic [ssrg_pkg::RATE_W-1:0]   cur_rate_min;

   stepper_step_rate_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_motor       (req_motor),
      .req_speed       (req_speed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_coils  (rsp_left_coils),
      .rsp_right_coils (rsp_right_coils),
      .rsp_left_steps  (rsp_left_steps),
      .rsp_right_steps (rsp_right_steps),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ssrg_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_motor       (req_motor),
      .req_speed       (req_speed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_coils  (rsp_left_coils),
      .rsp_right_coils (rsp_right_coils),
      .rsp_left_steps  (rsp_left_steps),
      .rsp_right_steps (rsp_right_steps),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("stepper_step_rate_generator test failed");
         $finish;
      end
   end

   task automatic send_word(input logic act, input logic [ssrg_pkg::MOTOR_W-1:0] mot,
                            input logic [ssrg_pkg::RATE_W-1:0] spd);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_motor <= mot;
      req_speed <= spd;
      do @(posedge clock); while (!req_ready);
      if (act == ssrg_pkg::ACT_SPEED) begin
         speed_words++;
      end else begin
         tick_words++;
      end
   endtask

   task automatic write_csr(input logic [ssrg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ssrg_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == ssrg_pkg::CSR_RATE_MAX) begin
         cur_rate_max = val;
      end else if (idx == ssrg_pkg::CSR_RATE_MIN) begin
         cur_rate_min = val;
      end
      csr_writes++;
   endtask

   // Hold the sender off until every expected word has come back, then let the
   // longest set-speed computation run out before anything else happens.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ssrg_pkg::RATE_W-1:0] pick_speed();
      int v;
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            v = int'($urandom_range(0, 65535));
         end
         3: begin
            v = int'(cur_rate_max) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         4: begin
            v = int'(cur_rate_min) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: begin
            case ($urandom_range(0, 2))
               0: v = 0;
               1: v = 32767;
               default: v = -32768;
            endcase
         end
      endcase
      return v[ssrg_pkg::RATE_W-1:0];
   endfunction

   task automatic program_settings();
      logic [ssrg_pkg::RATE_W-1:0] mx;
      logic [ssrg_pkg::RATE_W-1:0] mn;
      case ($urandom_range(0, 7))
         0: mx = 16'hFFFF;
         1: mx = 16'd1;
         2: mx = 16'd1000;
         3: mx = 16'd32767;
         4: mx = ssrg_pkg::RATE_W'($urandom_range(1, 65535));
         default: mx = ssrg_pkg::RATE_W'($urandom_range(2000, 30000));
      endcase
      case ($urandom_range(0, 5))
         0: mn = 16'd1;
         1: mn = 16'hFFFF;
         2: mn = ssrg_pkg::RATE_W'($urandom_range(1, 65535));
         default: mn = ssrg_pkg::RATE_W'($urandom_range(1, 300));
      endcase
      if ($urandom_range(0, 7) == 0) begin
         write_csr(CSR_SPARE, ssrg_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
      end
      write_csr(ssrg_pkg::CSR_ENABLED, ssrg_pkg::CSR_DATA_W'($urandom_range(0, 5) != 0));
      write_csr(ssrg_pkg::CSR_RATE_MAX, mx);
      write_csr(ssrg_pkg::CSR_RATE_MIN, mn);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ssrg_pkg::ACT_TICK;
      req_motor = '0;
      req_speed = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_rate_max = ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MAX_RESET);
      cur_rate_min = ssrg_pkg::RATE_W'(ssrg_pkg::RATE_MIN_RESET);
      sender_idle_pct = 14;
      receiver_idle_pct = 60;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Disabled after reset: ticks do nothing, speeds still load and clamp.
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'h7FFF);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, 16'h8000);
      send_word(ssrg_pkg::ACT_TICK, 1'b1, 16'hFFFF);
      settle();
      write_csr(ssrg_pkg::CSR_ENABLED, 16'd1);
      repeat (3) send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'd1000);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, -16'sd1000);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'd0);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, 16'd1);
      settle();
      write_csr(ssrg_pkg::CSR_RATE_MAX, 16'hFFFF);
      write_csr(ssrg_pkg::CSR_RATE_MIN, 16'hFFFF);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'h7FFF);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, 16'h8000);
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      settle();
      write_csr(ssrg_pkg::CSR_RATE_MAX, 16'd0);
      write_csr(ssrg_pkg::CSR_RATE_MIN, 16'd0);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'd5);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, 16'd0);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, -16'sd5);
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      settle();
      write_csr(CSR_SPARE, 16'hFFFF);
      write_csr(ssrg_pkg::CSR_RATE_MAX, 16'd32767);
      write_csr(ssrg_pkg::CSR_RATE_MIN, 16'd100);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'd99);
      send_word(ssrg_pkg::ACT_SPEED, 1'b1, -16'sd100);
      send_word(ssrg_pkg::ACT_SPEED, 1'b0, 16'd32767);
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);
      settle();
      write_csr(ssrg_pkg::CSR_ENABLED, 16'd0);
      send_word(ssrg_pkg::ACT_TICK, 1'b0, 16'h0000);

      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               sender_idle_pct = 14;
               receiver_idle_pct = 60;
            end
            1: begin
               sender_idle_pct = 60;
               receiver_idle_pct = 14;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int batch = 0; batch < BATCHES; batch++) begin
            settle();
            program_settings();
            for (int n = 0; n < BATCH_WORDS; n++) begin
               if ($urandom_range(0, 99) < 75) begin
                  send_word(ssrg_pkg::ACT_TICK, ssrg_pkg::MOTOR_W'($urandom_range(0, 1)),
                            ssrg_pkg::RATE_W'($urandom_range(0, 65535)));
               end else begin
                  send_word(ssrg_pkg::ACT_SPEED, ssrg_pkg::MOTOR_W'($urandom_range(0, 1)),
                            pick_speed());
               end
            end
         end
      end
      settle();

      $display("Covered %0d tick words and %0d set-speed words around %0d register writes,",
               tick_words, speed_words, csr_writes);
      $display("with sender and receiver stalls swapped between stages and a stall-free stage.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("stepper_step_rate_generator test passed");
      end else begin
         $display("stepper_step_rate_generator test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ssrg_pkg.sv
design/ssrg_ctrl.sv
design/ssrg_dp.sv
design/stepper_step_rate_generator.sv
dv/ssrg_checker.sv
dv/tb.sv
